// File: sv/aclp_pkg.sv
// Shared types and constants of the command line parser.
`timescale 1ns / 1ps
package aclp_pkg;
    localparam int LINE_DEPTH = 64;
    localparam int KEEP_MAX   = LINE_DEPTH - 1;
    localparam int AW         = $clog2(LINE_DEPTH);

    localparam logic [1:0] RESP_ERR = 2'd0;
    localparam logic [1:0] RESP_VER = 2'd1;
    localparam logic [1:0] RESP_OK  = 2'd2;
    localparam logic [1:0] RESP_SWP = 2'd3;

    localparam logic [1:0] GEN_NONE = 2'd0;
    localparam logic [1:0] GEN_ON   = 2'd1;
    localparam logic [1:0] GEN_OFF  = 2'd2;

    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_NUL = 8'h00;

    localparam logic [31:0] CENTRE_RESET = 32'd10000000;
    localparam logic [31:0] SPAN_RESET   = 32'd100000;
    localparam logic [31:0] BAND_RESET   = 32'd100000;
    localparam logic [31:0] START_FLOOR  = 32'd10;

    localparam logic [0:0] REG_BAND_MIN = 1'd0;

    // Queue entry between front and back: one byte event.
    typedef struct packed {
        logic       abandon;
        logic [7:0] data;
    } t_evt;

    typedef struct packed {
        logic [1:0]  response;
        logic [1:0]  gen_action;
        logic [31:0] start_hz;
        logic [31:0] step_hz;
        logic [32:0] points;
    } t_result;

    function automatic logic is_white(input logic [7:0] c);
        return (c == CH_SP) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction
endpackage

// File: sv/aclp_ram.sv
// Generic simple dual-port RAM (one write port, one read port) with registered read.
`timescale 1ns / 1ps
module aclp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// File: sv/aclp_front.sv
// Front end: filters received bytes and queues line events.
`timescale 1ns / 1ps
module aclp_front import aclp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_abandon_line,
    output logic       o_evt_valid,
    input  logic       i_evt_ready,
    output t_evt       o_evt
);
    // Two-entry queue.
    t_evt r_q [2];
    logic r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic push, pop, drop;
    t_evt evt;

    // Drop NUL, map tab to space.
    assign drop = !i_abandon_line && i_rx_byte == CH_NUL;
    assign evt.abandon = i_abandon_line;
    assign evt.data = (i_rx_byte == CH_TAB) ? CH_SP : i_rx_byte;

    assign o_ready = r_cnt != 2'd2;
    assign push = i_valid && o_ready && !drop;
    assign pop = o_evt_valid && i_evt_ready;
    assign o_evt_valid = r_cnt != 2'd0;
    assign o_evt = r_q[r_rp];

    always_comb begin
        n_wp = push ? !r_wp : r_wp;
        n_rp = pop ? !r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_cnt <= n_cnt;
        end
        if (push) begin
            r_q[r_wp] <= evt;
        end
    end
endmodule

// File: sv/aclp_div.sv
// Restoring 32-bit divider, one quotient bit a cycle.
`timescale 1ns / 1ps
module aclp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quot
);
    logic [31:0] r_q, r_d;
    logic [32:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [32:0] trial;

    assign trial = {r_rem[31:0], r_q[31]} - {1'b0, r_d};
    assign o_done = r_done;
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 6'd32;
                r_q <= i_num;
                r_d <= i_den;
                r_rem <= 33'd0;
            end else if (r_busy) begin
                // Shift in one numerator bit, subtract if it fits.
                if (!trial[32]) begin
                    r_rem <= trial;
                    r_q <= {r_q[30:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[31:0], r_q[31]};
                    r_q <= {r_q[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

// File: sv/aclp_back.sv
// Back end: stores the line and parses it at line end.
`timescale 1ns / 1ps
module aclp_back import aclp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_evt_valid,
    output logic        o_evt_ready,
    input  t_evt        i_evt,
    input  logic [31:0] i_band_min_hz,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_res
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TRIMS = 4'd1;
    localparam logic [3:0] S_TRIME = 4'd2;
    localparam logic [3:0] S_CMD   = 4'd3;
    localparam logic [3:0] S_NUM   = 4'd4;
    localparam logic [3:0] S_EXEC  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    localparam logic [2:0] K_FQ  = 3'd0;
    localparam logic [2:0] K_SW  = 3'd1;
    localparam logic [2:0] K_FRX = 3'd2;

    logic [3:0]    r_st;
    logic [AW-1:0] r_len, r_s, r_e, r_p, raddr;
    logic [AW-1:0] r_ra;
    logic          r_rd_ok;      // read data matches r_ra
    logic [7:0]    rdata;
    logic [7:0]    r_c [3];      // first three trimmed chars, lowered
    logic [1:0]    r_ci;
    logic [2:0]    r_kind;
    logic          r_dig, r_numend;
    logic [31:0]   r_v;
    logic [31:0]   r_centre, r_span;
    t_result       r_res;
    logic          r_ov;
    logic          we, dstart, ddone;
    logic [31:0]   dq;
    logic [AW-1:0] tlen;
    logic [35:0]   v10;

    assign o_evt_ready = (r_st == S_IDLE) && !r_ov;
    assign we = i_evt_valid && o_evt_ready && !i_evt.abandon &&
                i_evt.data != CH_CR && i_evt.data != CH_LF && r_len < AW'(KEEP_MAX);

    aclp_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_len), .i_wdata(i_evt.data),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    aclp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dstart),
        .i_num(r_span), .i_den(r_v), .o_done(ddone), .o_quot(dq)
    );

    assign raddr = r_p;
    assign tlen = r_e - r_s;
    assign dstart = (r_st == S_EXEC) && r_kind == K_FRX && r_dig && r_v != 32'd0;
    assign v10 = {1'b0, r_v, 3'd0} + {3'd0, r_v, 1'b0} + {32'd0, rdata[3:0]} - 36'd0;
    assign o_valid = r_ov;
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_len <= '0;
            r_ov <= 1'b0;
            r_centre <= CENTRE_RESET;
            r_span <= SPAN_RESET;
            r_rd_ok <= 1'b0;
        end else begin
            r_ra <= r_p;
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                S_IDLE: begin
                    if (i_evt_valid && o_evt_ready) begin
                        if (i_evt.abandon) begin
                            r_len <= '0;
                        end else if (i_evt.data == CH_CR || i_evt.data == CH_LF) begin
                            r_e <= r_len;
                            r_s <= '0;
                            r_p <= '0;
                            r_len <= '0;
                            r_rd_ok <= 1'b0;
                            r_st <= S_TRIMS;
                        end else if (we) begin
                            r_len <= r_len + AW'(1);
                        end
                    end
                end
                // Advance start past white space; rdata is valid in the cycle after r_p.
                S_TRIMS: begin
                    r_rd_ok <= 1'b1;
                    if (r_s == r_e) begin
                        r_st <= S_TRIME;
                    end else if (r_rd_ok && r_ra == r_s) begin
                        if (is_white(rdata)) begin
                            r_s <= r_s + AW'(1);
                            r_p <= r_s + AW'(1);
                            r_rd_ok <= 1'b0;
                        end else begin
                            r_p <= r_e - AW'(1);
                            r_rd_ok <= 1'b0;
                            r_st <= S_TRIME;
                        end
                    end
                end
                S_TRIME: begin
                    r_rd_ok <= 1'b1;
                    if (r_e == r_s) begin
                        r_res <= '0;
                        r_ov <= 1'b1;
                        r_st <= S_OUT;
                    end else if (r_rd_ok && r_ra == r_e - AW'(1)) begin
                        if (is_white(rdata)) begin
                            r_e <= r_e - AW'(1);
                            r_p <= r_e - AW'(2);
                            r_rd_ok <= 1'b0;
                        end else begin
                            r_p <= r_s;
                            r_ci <= 2'd0;
                            r_rd_ok <= 1'b0;
                            r_c[0] <= 8'h00;
                            r_c[1] <= 8'h00;
                            r_c[2] <= 8'h00;
                            r_st <= S_CMD;
                        end
                    end
                end
                // Fetch up to three leading characters.
                S_CMD: begin
                    r_rd_ok <= 1'b1;
                    if (r_ci == 2'd3 || AW'(r_ci) == tlen) begin
                        r_st <= S_NUM;
                        r_dig <= 1'b0;
                        r_numend <= 1'b0;
                        r_v <= '0;
                        r_rd_ok <= 1'b0;
                        if (r_c[0] == 8'h66 && r_c[1] == 8'h71) begin
                            r_kind <= K_FQ;
                            r_p <= r_s + AW'(2);
                        end else if (r_c[0] == 8'h73 && r_c[1] == 8'h77) begin
                            r_kind <= K_SW;
                            r_p <= r_s + AW'(2);
                        end else begin
                            r_kind <= K_FRX;
                            r_p <= r_s + AW'(3);
                        end
                    end else if (r_rd_ok && r_ra == r_p) begin
                        r_c[r_ci] <= lower(rdata);
                        r_ci <= r_ci + 2'd1;
                        r_p <= r_p + AW'(1);
                        r_rd_ok <= 1'b0;
                    end
                end
                // Accumulate the digit run with saturation.
                S_NUM: begin
                    r_rd_ok <= 1'b1;
                    if (r_numend || r_p >= r_e) begin
                        r_st <= S_EXEC;
                    end else if (r_rd_ok && r_ra == r_p) begin
                        r_rd_ok <= 1'b0;
                        if (is_digit(rdata)) begin
                            r_dig <= 1'b1;
                            r_v <= (v10[35:32] != 4'd0) ? 32'hffffffff : v10[31:0];
                            r_p <= r_p + AW'(1);
                        end else begin
                            r_numend <= 1'b1;
                        end
                    end
                end
                S_EXEC: begin
                    r_res <= '0;
                    r_st <= S_OUT;
                    r_ov <= 1'b1;
                    if (tlen == AW'(3) && r_c[0] == 8'h76 && r_c[1] == 8'h65
                        && r_c[2] == 8'h72) begin
                        r_res.response <= RESP_VER;
                    end else if (tlen == AW'(2) && r_c[0] == 8'h6f && r_c[1] == 8'h6e) begin
                        r_res.response <= RESP_OK;
                        r_res.gen_action <= GEN_ON;
                    end else if (tlen == AW'(3) && r_c[0] == 8'h6f && r_c[1] == 8'h66
                                 && r_c[2] == 8'h66) begin
                        r_res.response <= RESP_OK;
                        r_res.gen_action <= GEN_OFF;
                    end else if (tlen >= AW'(2) &&
                                 ((r_c[0] == 8'h61 && r_c[1] == 8'h6d) ||
                                  (r_c[0] == 8'h70 && r_c[1] == 8'h68) ||
                                  (r_c[0] == 8'h64 && r_c[1] == 8'h65))) begin
                        r_res.response <= RESP_OK;
                    end else if (tlen >= AW'(2) && r_kind == K_FQ) begin
                        if (r_dig && r_v >= i_band_min_hz) begin
                            r_centre <= r_v;
                            r_res.response <= RESP_OK;
                        end
                    end else if (tlen >= AW'(2) && r_kind == K_SW) begin
                        if (r_dig) begin
                            r_span <= r_v;
                            r_res.response <= RESP_OK;
                        end
                    end else if (tlen >= AW'(3) && r_c[0] == 8'h66 && r_c[1] == 8'h72
                                 && r_c[2] == 8'h78 && r_dig && r_v != 32'd0) begin
                        r_ov <= 1'b0;
                        r_st <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (ddone) begin
                        r_res.response <= RESP_SWP;
                        r_res.start_hz <= ({1'b0, r_span[31:1]} > r_centre) ? START_FLOOR
                                          : r_centre - {1'b0, r_span[31:1]};
                        r_res.step_hz <= dq;
                        r_res.points <= {1'b0, r_v} + 33'd1;
                        r_ov <= 1'b1;
                        r_st <= S_OUT;
                    end
                end
                // Hold until the result is taken.
                S_OUT: begin
                    if (!r_ov || i_ready) begin
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// File: sv/analyzer_command_line_parser.sv
// Top level of the serial command line parser.
// Channels: input bytes (i_rx_byte, i_abandon_line) under i_valid/o_ready;
// results under o_valid/i_ready, one per CR or LF; config over APB.
// Ordinary bytes pass a two-entry queue and are stored in the line store.
// A line end walks the line store one read at a time for trimming,
// command letters and digits, then the frx command runs the 32-bit
// divider (one quotient bit a cycle).
// The back end takes no new event until its result is taken; while the
// receiver stalls, the front queue still takes up to two bytes.
// Reset (synchronous, active low) empties the line, sets centre 10 MHz,
// span 100 kHz and band minimum 100 kHz. No clearing pass is needed.
// Register 0 at address 0: band minimum in hertz, read back on prdata.
`timescale 1ns / 1ps
module analyzer_command_line_parser import aclp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_abandon_line,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_response,
    output logic [1:0]  o_gen_action,
    output logic [31:0] o_sweep_start_hz,
    output logic [31:0] o_sweep_step_hz,
    output logic [32:0] o_sweep_points,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic    evt_valid, evt_ready;
    t_evt    evt;
    t_result res;
    logic [31:0] r_band;

    // Config register.
    assign pready = 1'b1;
    assign prdata = (paddr == REG_BAND_MIN) ? r_band : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band <= BAND_RESET;
        end else if (psel && penable && pwrite && paddr == REG_BAND_MIN) begin
            r_band <= pwdata;
        end
    end

    aclp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_rx_byte(i_rx_byte), .i_abandon_line(i_abandon_line),
        .o_evt_valid(evt_valid), .i_evt_ready(evt_ready), .o_evt(evt)
    );

    aclp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_evt_valid(evt_valid),
        .o_evt_ready(evt_ready), .i_evt(evt), .i_band_min_hz(r_band),
        .o_valid(o_valid), .i_ready(i_ready), .o_res(res)
    );

    assign o_response = res.response;
    assign o_gen_action = res.gen_action;
    assign o_sweep_start_hz = res.start_hz;
    assign o_sweep_step_hz = res.step_hz;
    assign o_sweep_points = res.points;

    // Only sweep results carry a point count.
    a_points: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_response != RESP_SWP |-> o_sweep_points == 33'd0)
        else $error("points set outside sweep result");
    // Generator action comes only with ok.
    a_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_gen_action != GEN_NONE |-> o_response == RESP_OK)
        else $error("generator action without ok");
    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sweep_step_hz))
        else $error("result dropped while stalled");
endmodule
